// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== hw/rtl/u8v_pkg.sv =====
// Types, constants and helpers for the UTF-8 stream validator.
package u8v_pkg;

  localparam int POSITION_BITS = 16;
  localparam int OFFSET_BITS   = 16;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [OFFSET_BITS-1:0]   offset_t;

  localparam pos_t    POS_MAX    = {POSITION_BITS{1'b1}};
  localparam offset_t OFFSET_MAX = {OFFSET_BITS{1'b1}};

  // Byte class masks and codes.
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'he0;
  localparam logic [7:0] LEAD2_CODE = 8'hc0;
  localparam logic [7:0] LEAD3_MASK = 8'hf0;
  localparam logic [7:0] LEAD3_CODE = 8'he0;
  localparam logic [7:0] LEAD4_MASK = 8'hf8;
  localparam logic [7:0] LEAD4_CODE = 8'hf0;
  localparam logic [7:0] PAIR_MASK  = 8'hfe;

  // Special lead and second-byte values.
  localparam logic [7:0] LEAD_E0    = 8'he0;
  localparam logic [7:0] LEAD_ED    = 8'hed;
  localparam logic [7:0] LEAD_EF    = 8'hef;
  localparam logic [7:0] LEAD_F0    = 8'hf0;
  localparam logic [7:0] LEAD_F4    = 8'hf4;
  localparam logic [7:0] BYTE_BF    = 8'hbf;
  localparam logic [7:0] BYTE_BE    = 8'hbe;
  localparam logic [7:0] BYTE_A0    = 8'ha0;
  localparam logic [7:0] BYTE_8F    = 8'h8f;
  localparam logic [7:0] BYTE_80    = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic    is_valid;
    offset_t error_offset;
  } result_t;

  typedef struct packed {
    logic [1:0] continuation_left;
    logic [7:0] lead_value;
    logic [7:0] second_value;
    pos_t       lead_position;
    pos_t       byte_position;
    logic       error_found;
    pos_t       first_error_position;
  } scan_state_t;

  // Sequence length implied by a lead byte (2, 3 or 4).
  function automatic logic [2:0] seq_length(input logic [7:0] lead);
    if ((lead & LEAD2_MASK) == LEAD2_CODE) return 3'd2;
    if ((lead & LEAD3_MASK) == LEAD3_CODE) return 3'd3;
    return 3'd4;
  endfunction

  // Clamp a position to the width of the reported offset.
  function automatic offset_t sat_offset(input pos_t p);
    if (32'(p) > 32'(OFFSET_MAX)) return OFFSET_MAX;
    return OFFSET_BITS'(p);
  endfunction

endpackage

// ===== hw/rtl/u8v_step.sv =====
// Per-byte decision: next scan state and the end-of-string result.
module u8v_step (
  input  u8v_pkg::scan_state_t cur,
  input  u8v_pkg::byte_t       in_byte,
  output u8v_pkg::scan_state_t nxt,
  output u8v_pkg::result_t     result
);
  import u8v_pkg::*;

  logic [7:0] c;
  logic [2:0] index;
  logic       bad;

  assign c = in_byte.data_byte;

  always_comb begin
    nxt    = cur;
    index  = 3'd0;
    bad    = 1'b0;
    result = '0;

    if (!cur.error_found) begin
      if (cur.continuation_left == 2'd0) begin
        nxt.lead_value    = c;
        nxt.second_value  = 8'd0;
        nxt.lead_position = cur.byte_position;
        if (c[7] == 1'b0) begin
          nxt.continuation_left = 2'd0;
        end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
          if ((c & PAIR_MASK) == LEAD2_CODE) begin
            nxt.error_found          = 1'b1;
            nxt.first_error_position = cur.byte_position;
          end else begin
            nxt.continuation_left = 2'd1;
          end
        end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
          nxt.continuation_left = 2'd2;
        end else if ((c & LEAD4_MASK) == LEAD4_CODE && c <= LEAD_F4) begin
          nxt.continuation_left = 2'd3;
        end else begin
          nxt.error_found          = 1'b1;
          nxt.first_error_position = cur.byte_position;
        end
      end else begin
        index = seq_length(cur.lead_value) - {1'b0, cur.continuation_left};
        if ((c & CONT_MASK) != CONT_CODE) begin
          bad = 1'b1;
        end else if (index == 3'd1) begin
          nxt.second_value = c;
          if (cur.lead_value == LEAD_E0 && (c & LEAD2_MASK) == BYTE_80) bad = 1'b1;
          if (cur.lead_value == LEAD_ED && (c & LEAD2_MASK) == BYTE_A0) bad = 1'b1;
          if (cur.lead_value == LEAD_F0 && (c & LEAD3_MASK) == BYTE_80) bad = 1'b1;
          if (cur.lead_value == LEAD_F4 && c > BYTE_8F) bad = 1'b1;
        end else if (index == 3'd2) begin
          if (cur.lead_value == LEAD_EF && cur.second_value == BYTE_BF &&
              (c & PAIR_MASK) == BYTE_BE) bad = 1'b1;
        end
        if (bad) begin
          nxt.error_found          = 1'b1;
          nxt.first_error_position = cur.lead_position;
          nxt.continuation_left    = 2'd0;
        end else begin
          nxt.continuation_left = cur.continuation_left - 2'd1;
        end
      end
    end

    if (in_byte.last_byte) begin
      // A sequence still open at the end of the string is truncated.
      if (!nxt.error_found && nxt.continuation_left != 2'd0) begin
        nxt.error_found          = 1'b1;
        nxt.first_error_position = nxt.lead_position;
      end
      result.is_valid     = !nxt.error_found;
      result.error_offset = nxt.error_found ? sat_offset(nxt.first_error_position) : '0;
      nxt = '0;
    end else if (cur.byte_position != POS_MAX) begin
      nxt.byte_position = cur.byte_position + pos_t'(1);
    end
  end

endmodule

// ===== hw/rtl/u8v_result_reg.sv =====
// Output register that holds one result until the consumer takes it.
module u8v_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  u8v_pkg::result_t load_data,
  output logic             free,
  output logic             result_valid,
  input  logic             result_ready,
  output u8v_pkg::result_t result_data
);
  import u8v_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= load_data;
    end
  end

endmodule

// ===== hw/rtl/utf8_stream_validator.sv =====
// Top level: streaming UTF-8 well-formedness check, one byte per clock.
// Throughput: one byte per cycle unless stalled, set by the scan state update.
// The result appears in the cycle after the transfer of the final byte.
// A waiting result stalls byte input only until the result register frees up.
// Reset (rst, synchronous, active high) clears the scan state and drops any
// pending result.
module utf8_stream_validator (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_ready,
  input  u8v_pkg::byte_t   byte_data,
  output logic             result_valid,
  input  logic             result_ready,
  output u8v_pkg::result_t result_data
);
  import u8v_pkg::*;

  scan_state_t scan;
  scan_state_t scan_next;
  result_t     step_result;
  logic        byte_xfer;
  logic        out_free;

  // Accept a byte whenever the result register can take whatever it causes;
  // the register frees up in the same cycle the consumer takes its result.
  assign byte_ready = out_free;
  assign byte_xfer  = byte_valid && byte_ready;

  // Decide the fate of the incoming byte from the current scan state.
  u8v_step u_step (
    .cur     (scan),
    .in_byte (byte_data),
    .nxt     (scan_next),
    .result  (step_result)
  );

  // Advance the scan state only on a transfer; hold it otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (byte_xfer) begin
      scan <= scan_next;
    end
  end

  // Load a result only on the transfer of the final byte of a string.
  u8v_result_reg u_result (
    .clk          (clk),
    .rst          (rst),
    .load         (byte_xfer && byte_data.last_byte),
    .load_data    (step_result),
    .free         (out_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

// ===== hw/rtl/u8v_checker.sv =====
// Port-level checks for the UTF-8 stream validator, bound to the top level.
`include "assert_macros.svh"

module u8v_checker (
  input logic             clk,
  input logic             rst,
  input logic             byte_valid,
  input logic             byte_ready,
  input u8v_pkg::byte_t   byte_data,
  input logic             result_valid,
  input logic             result_ready,
  input u8v_pkg::result_t result_data
);
  import u8v_pkg::*;

  logic result_stall;
  logic last_xfer;
  logic out_free;
  logic valid_verdict;

  assign result_stall  = result_valid && !result_ready;
  assign last_xfer     = byte_valid && byte_ready && byte_data.last_byte;
  assign out_free      = !result_valid || result_ready;
  assign valid_verdict = result_valid && result_data.is_valid;

  `ASSERT_NEXT(a_result_hold, clk, rst, result_stall, result_valid && $stable(result_data))
  `ASSERT_NEXT(a_last_gives_result, clk, rst, last_xfer, result_valid)
  `ASSERT_NEXT(a_no_phantom, clk, rst, out_free && !last_xfer, !result_valid)
  `ASSERT_SAME(a_valid_zero_offset, clk, rst, valid_verdict, result_data.error_offset == '0)

endmodule

bind utf8_stream_validator u8v_checker u_checker (.*);

// ===== dv/utf8_result_checker.sv =====
// Checker for the UTF-8 validator: predicts each string's verdict and compares.
module utf8_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  input  logic             byte_ready,
  input  u8v_pkg::byte_t   byte_data,
  input  logic             result_valid,
  input  logic             result_ready,
  input  u8v_pkg::result_t result_data,
  output int               fail_count,
  output int               results_pending
);
  import u8v_pkg::*;

  // Scan state of the string in progress.
  logic [1:0] cont_left;
  logic [7:0] lead_byte;
  logic [7:0] second_byte;
  pos_t       lead_pos;
  pos_t       byte_pos;
  logic       bad_seen;
  pos_t       first_bad_pos;

  result_t    expected_verdicts[$];
  int         mismatches;

  task automatic clear_scan();
    cont_left     = 2'd0;
    lead_byte     = 8'h00;
    second_byte   = 8'h00;
    lead_pos      = '0;
    byte_pos      = '0;
    bad_seen      = 1'b0;
    first_bad_pos = '0;
  endtask

  // Keep only the first error of a string; any error ends the sequence.
  task automatic mark_bad(input pos_t where);
    if (!bad_seen) begin
      bad_seen      = 1'b1;
      first_bad_pos = where;
    end
    cont_left = 2'd0;
  endtask

  task automatic open_sequence(input logic [7:0] c);
    lead_byte   = c;
    second_byte = 8'h00;
    lead_pos    = byte_pos;
    if (c[7]) begin
      if ((c & LEAD2_MASK) == LEAD2_CODE) begin
        // C0 and C1 can only encode overlong ASCII
        if ((c & PAIR_MASK) == LEAD2_CODE) mark_bad(byte_pos);
        else cont_left = 2'd1;
      end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
        cont_left = 2'd2;
      end else if ((c & LEAD4_MASK) == LEAD4_CODE) begin
        if (c > LEAD_F4) mark_bad(byte_pos);
        else cont_left = 2'd3;
      end else begin
        mark_bad(byte_pos);
      end
    end
  endtask

  task automatic extend_sequence(input logic [7:0] c);
    int   total;
    int   idx;
    logic bad;
    bad = 1'b0;
    if ((c & CONT_MASK) != CONT_CODE) begin
      mark_bad(lead_pos);
      return;
    end
    if ((lead_byte & LEAD2_MASK) == LEAD2_CODE) total = 2;
    else if ((lead_byte & LEAD3_MASK) == LEAD3_CODE) total = 3;
    else total = 4;
    idx = total - int'(cont_left);
    if (idx == 1) begin
      second_byte = c;
      if (lead_byte == LEAD_E0 && (c & LEAD2_MASK) == BYTE_80) bad = 1'b1;
      if (lead_byte == LEAD_ED && (c & LEAD2_MASK) == BYTE_A0) bad = 1'b1;
      if (lead_byte == LEAD_F0 && (c & LEAD3_MASK) == BYTE_80) bad = 1'b1;
      if (lead_byte == LEAD_F4 && c > BYTE_8F) bad = 1'b1;
    end else if (idx == 2) begin
      if (lead_byte == LEAD_EF && second_byte == BYTE_BF && (c & PAIR_MASK) == BYTE_BE)
        bad = 1'b1;
    end
    if (bad) mark_bad(lead_pos);
    else cont_left = cont_left - 2'd1;
  endtask

  task automatic scan_byte(input byte_t b);
    result_t want;
    if (!bad_seen) begin
      if (cont_left == 2'd0) open_sequence(b.data_byte);
      else extend_sequence(b.data_byte);
    end
    if (!b.last_byte) begin
      if (byte_pos != POS_MAX) byte_pos = byte_pos + pos_t'(1);
    end else begin
      // a sequence still open at the final byte is truncated
      if (!bad_seen && cont_left != 2'd0) mark_bad(lead_pos);
      want.is_valid     = !bad_seen;
      want.error_offset = '0;
      if (bad_seen)
        want.error_offset = (first_bad_pos > OFFSET_MAX) ? OFFSET_MAX
                                                         : offset_t'(first_bad_pos);
      expected_verdicts.push_back(want);
      clear_scan();
    end
  endtask

  task automatic check_verdict(input result_t got);
    result_t want;
    if (expected_verdicts.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual is_valid=%0d error_offset=%0d",
               $time, got.is_valid, got.error_offset);
      mismatches++;
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.is_valid !== want.is_valid) begin
      $display("%0t: is_valid mismatch: expected %0d, actual %0d",
               $time, want.is_valid, got.is_valid);
      mismatches++;
    end
    if (got.error_offset !== want.error_offset) begin
      $display("%0t: error_offset mismatch: expected %0d, actual %0d",
               $time, want.error_offset, got.error_offset);
      mismatches++;
    end
  endtask

  initial begin
    clear_scan();
    mismatches = 0;
  end

  // Check the result transfer before scanning the byte of the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      expected_verdicts.delete();
    end else begin
      if (result_valid && result_ready) check_verdict(result_data);
      if (byte_valid && byte_ready) scan_byte(byte_data);
    end
    results_pending <= expected_verdicts.size();
    fail_count      <= mismatches;
  end

endmodule

// ===== dv/utf8_stream_validator_tb.sv =====
// Testbench top: byte stimulus, result pacing and verdict for the UTF-8 validator.
module utf8_stream_validator_tb;
  import u8v_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_BYTES  = 1400;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    byte_valid   = 1'b0;
  logic    byte_ready;
  byte_t   byte_data    = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result_data;

  int      fail_count;
  int      results_pending;
  int      cycle_count  = 0;
  int      burst_left   = 0;
  logic    hold_req     = 1'b0;

  // Bytes of the string currently being built or sent.
  logic [7:0] text_buf[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf8_stream_validator u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  utf8_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_ready      (byte_ready),
    .byte_data       (byte_data),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_data     (result_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  // Guard against a hung handshake: end the run at a generous cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall on random patterns of random span. Once the stimulus asks
  // for it, hold off for a long stretch so the block backs up into its input.
  initial begin : result_pacer
    int mode;
    int span;
    bit hold_taken;
    hold_taken = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(3, 0);
        span = $urandom_range(64, 8);
        repeat (span) begin
          case (mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(1, 0));
            2:       result_ready <= ($urandom_range(3, 0) == 0);
            default: result_ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Pick a bound half of the time so range edges get hit often.
  function automatic logic [7:0] edge_pick(input logic [7:0] lo, input logic [7:0] hi);
    case ($urandom_range(3, 0))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [7:0] any_cont();
    return 8'($urandom_range(BYTE_BF, BYTE_80));
  endfunction

  // Append one well-formed character, biased toward the special leads.
  task automatic append_char();
    int         kind;
    logic [7:0] lead;
    logic [7:0] second;
    kind = $urandom_range(9, 0);
    if (kind < 3) begin
      text_buf.push_back(8'($urandom_range(8'h7f, 8'h00)));
    end else if (kind < 5) begin
      text_buf.push_back(edge_pick(8'hc2, 8'hdf));
      text_buf.push_back(edge_pick(BYTE_80, BYTE_BF));
    end else if (kind < 8) begin
      case ($urandom_range(3, 0))
        0:       lead = LEAD_E0;
        1:       lead = LEAD_ED;
        2:       lead = LEAD_EF;
        default: lead = 8'($urandom_range(LEAD_EF, LEAD_E0));
      endcase
      if (lead == LEAD_E0) second = edge_pick(BYTE_A0, BYTE_BF);
      else if (lead == LEAD_ED) second = edge_pick(BYTE_80, 8'h9f);
      else second = edge_pick(BYTE_80, BYTE_BF);
      text_buf.push_back(lead);
      text_buf.push_back(second);
      // EF BF BE and EF BF BF are noncharacters; stop just below them
      if (lead == LEAD_EF && second == BYTE_BF) text_buf.push_back(edge_pick(BYTE_80, 8'hbd));
      else text_buf.push_back(edge_pick(BYTE_80, BYTE_BF));
    end else begin
      case ($urandom_range(2, 0))
        0:       lead = LEAD_F0;
        1:       lead = LEAD_F4;
        default: lead = 8'($urandom_range(8'hf3, 8'hf1));
      endcase
      if (lead == LEAD_F0) second = edge_pick(8'h90, BYTE_BF);
      else if (lead == LEAD_F4) second = edge_pick(BYTE_80, BYTE_8F);
      else second = edge_pick(BYTE_80, BYTE_BF);
      text_buf.push_back(lead);
      text_buf.push_back(second);
      text_buf.push_back(edge_pick(BYTE_80, BYTE_BF));
      text_buf.push_back(edge_pick(BYTE_80, BYTE_BF));
    end
  endtask

  // Spoil: replaced, stray or invalid byte, bad pair, cut short, no continuation.
  task automatic spoil_text();
    int         where;
    int         cut;
    logic [7:0] piece[$];
    where = $urandom_range(text_buf.size(), 0);
    case ($urandom_range(5, 0))
      0: text_buf[$urandom_range(text_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
      1: piece.push_back(any_cont());
      2: begin
        if ($urandom_range(1, 0) == 0) piece.push_back(edge_pick(8'hc0, 8'hc1));
        else piece.push_back(edge_pick(8'hf5, 8'hff));
      end
      3: begin
        case ($urandom_range(4, 0))
          0: begin
            piece.push_back(LEAD_E0);
            piece.push_back(edge_pick(BYTE_80, 8'h9f));
          end
          1: begin
            piece.push_back(LEAD_ED);
            piece.push_back(edge_pick(BYTE_A0, BYTE_BF));
          end
          2: begin
            piece.push_back(LEAD_F0);
            piece.push_back(edge_pick(BYTE_80, BYTE_8F));
          end
          3: begin
            piece.push_back(LEAD_F4);
            piece.push_back(edge_pick(8'h90, BYTE_BF));
          end
          default: begin
            piece.push_back(LEAD_EF);
            piece.push_back(BYTE_BF);
            piece.push_back(edge_pick(BYTE_BE, BYTE_BF));
          end
        endcase
      end
      4: begin
        // lead cut short by the end of the string
        case ($urandom_range(2, 0))
          0:       begin piece.push_back(8'($urandom_range(8'hdf, 8'hc2))); cut = 0; end
          1:       begin piece.push_back(8'($urandom_range(8'hec, 8'he1))); cut = 1; end
          default: begin piece.push_back(8'($urandom_range(8'hf3, 8'hf1))); cut = 2; end
        endcase
        repeat ($urandom_range(cut, 0)) piece.push_back(any_cont());
        where = text_buf.size();
      end
      default: begin
        // continuation expected, something else arrives
        if ($urandom_range(1, 0) == 0) begin
          piece.push_back(8'($urandom_range(8'hdf, 8'hc2)));
        end else begin
          piece.push_back(8'($urandom_range(8'hec, 8'he1)));
          piece.push_back(any_cont());
        end
        if ($urandom_range(1, 0) == 0) piece.push_back(8'($urandom_range(8'h7f, 8'h00)));
        else piece.push_back(8'($urandom_range(8'hff, 8'hc0)));
      end
    endcase
    foreach (piece[i]) text_buf.insert(where + i, piece[i]);
  endtask

  task automatic build_text();
    text_buf.delete();
    if ($urandom_range(19, 0) == 0) begin
      repeat ($urandom_range(10, 1)) text_buf.push_back(8'($urandom_range(255, 0)));
    end else begin
      repeat ($urandom_range(8, 1)) append_char();
      if ($urandom_range(99, 0) < 35) spoil_text();
      if ($urandom_range(9, 0) == 0) spoil_text();
    end
  endtask

  // Offer one byte; the sender runs in bursts with random gaps in between.
  task automatic send_byte(input logic [7:0] value, input logic ends_text);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(24, 1);
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_data  <= '{data_byte: value, last_byte: ends_text};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Hold the sender until every predicted verdict has been transferred.
  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int random_sent;
    int texts_sent;
    random_sent = 0;
    texts_sent  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: NUL as plain ASCII, top of the one- and two-byte classes,
    // C1 overlong, stray continuation, E0/F0 overlong, surrogate, noncharacter,
    // above U+10FFFF, F5 lead, truncation, and bytes ignored after an error.
    text_buf = '{8'h00};                    send_text();
    text_buf = '{8'h7f, 8'hdf, 8'hbf};      send_text();
    text_buf = '{8'hc1};                    send_text();
    text_buf = '{8'h41, 8'h80};             send_text();
    text_buf = '{8'he0, 8'h9f};             send_text();
    text_buf = '{8'hed, 8'ha0};             send_text();
    text_buf = '{8'hef, 8'hbf, 8'hbf};      send_text();
    text_buf = '{8'hf4, 8'h90};             send_text();
    text_buf = '{8'hf0, 8'h8f};             send_text();
    text_buf = '{8'hf5};                    send_text();
    text_buf = '{8'he2, 8'h82};             send_text();
    text_buf = '{8'hc3, 8'h41, 8'hff};      send_text();
    drain_results();

    // Request the long receiver hold-off; keep offering strings behind it.
    hold_req <= 1'b1;

    while (random_sent < RANDOM_BYTES) begin
      build_text();
      random_sent += text_buf.size();
      send_text();
      texts_sent++;
      if (texts_sent % 25 == 0) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
